>>> sv/ppe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Package for the prime partition core: sizes, microcode encodings and the control store.
// Used by ppe_rem and prime_partition_to_end_core; depends on nothing.

package ppe_pkg;

	localparam int MAX_ELEMENTS_DEF = 64;
	localparam int VALUE_BITS_DEF   = 16;

	localparam int STEP_BITS = 5;
	typedef logic [STEP_BITS-1:0] step_t;

	// program steps
	localparam step_t S_LOAD       = 5'd0;
	localparam step_t S_FL_INIT    = 5'd1;
	localparam step_t S_FL_CHK     = 5'd2;
	localparam step_t S_FL_RD      = 5'd3;
	localparam step_t S_FL_LD      = 5'd4;
	localparam step_t S_T_LT2      = 5'd5;
	localparam step_t S_T_LT4      = 5'd6;
	localparam step_t S_T_EVEN     = 5'd7;
	localparam step_t S_SQ         = 5'd8;
	localparam step_t S_SQ_CMP     = 5'd9;
	localparam step_t S_DIV        = 5'd10;
	localparam step_t S_DIV_CHK    = 5'd11;
	localparam step_t S_NEXT_D     = 5'd12;
	localparam step_t S_NOTP       = 5'd13;
	localparam step_t S_ISP        = 5'd14;
	localparam step_t S_PT_INIT    = 5'd15;
	localparam step_t S_PT_TOP     = 5'd16;
	localparam step_t S_PT_DEC     = 5'd17;
	localparam step_t S_PT_RD      = 5'd18;
	localparam step_t S_PT_CHK     = 5'd19;
	localparam step_t S_SC_TOP     = 5'd20;
	localparam step_t S_SC_CHK     = 5'd21;
	localparam step_t S_SC_INC     = 5'd22;
	localparam step_t S_SWAP_A     = 5'd23;
	localparam step_t S_SWAP_B     = 5'd24;
	localparam step_t S_EM_INIT    = 5'd25;
	localparam step_t S_EM_RD      = 5'd26;
	localparam step_t S_EM_LD      = 5'd27;
	localparam step_t S_EM_CHK     = 5'd28;
	localparam step_t S_FIN        = 5'd29;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_CLR_IDX,
		OP_LD_V,
		OP_D_INIT,
		OP_SQ,
		OP_REM_START,
		OP_D_ADD2,
		OP_WR_NP,
		OP_WR_P,
		OP_PT_INIT,
		OP_DEC_SLOT,
		OP_LD_A,
		OP_INC_SCAN,
		OP_WR_SLOT_RD,
		OP_WR_SCAN_A,
		OP_OUT_LD,
		OP_CLR_CNT
	} op_t;

	typedef enum logic [3:0] {
		C_NONE,
		C_ALWAYS,
		C_NOT_CLOSE,
		C_IDX_DONE,
		C_IDX_MORE,
		C_V_LT2,
		C_V_LT4,
		C_V_EVEN,
		C_SQ_GT_V,
		C_REM_BUSY,
		C_REM_ZERO,
		C_SLOT_ZERO,
		C_RD_FLAG,
		C_SCAN_GE_SLOT,
		C_OUT_HOLD
	} cond_t;

	typedef enum logic [1:0] {
		ADDR_IDX,
		ADDR_SLOT,
		ADDR_SCAN
	} addr_sel_t;

	typedef struct packed {
		logic      rdy;
		logic      rd_en;
		addr_sel_t rd_sel;
		op_t       op;
		cond_t     cond;
		step_t     target;
	} ctrl_t;

	typedef struct packed {
		logic busy;
		logic zero;
	} rem_stat_t;

	function automatic ctrl_t mk(input logic rdy, input logic rd_en, input addr_sel_t sel,
			input op_t op, input cond_t cond, input step_t target);
		ctrl_t c;
		c.rdy    = rdy;
		c.rd_en  = rd_en;
		c.rd_sel = sel;
		c.op     = op;
		c.cond   = cond;
		c.target = target;
		return c;
	endfunction

	// control store: jump to target when cond holds, else fall through
	function automatic ctrl_t ucode(input step_t pc);
		ctrl_t c;
		unique case (pc)
			S_LOAD:    c = mk(1'b1, 1'b0, ADDR_IDX,  OP_LOAD,       C_NOT_CLOSE,    S_LOAD);
			S_FL_INIT: c = mk(1'b0, 1'b0, ADDR_IDX,  OP_CLR_IDX,    C_NONE,         S_LOAD);
			S_FL_CHK:  c = mk(1'b0, 1'b0, ADDR_IDX,  OP_NONE,       C_IDX_DONE,     S_PT_INIT);
			S_FL_RD:   c = mk(1'b0, 1'b1, ADDR_IDX,  OP_NONE,       C_NONE,         S_LOAD);
			S_FL_LD:   c = mk(1'b0, 1'b0, ADDR_IDX,  OP_LD_V,       C_NONE,         S_LOAD);
			S_T_LT2:   c = mk(1'b0, 1'b0, ADDR_IDX,  OP_NONE,       C_V_LT2,        S_NOTP);
			S_T_LT4:   c = mk(1'b0, 1'b0, ADDR_IDX,  OP_NONE,       C_V_LT4,        S_ISP);
			S_T_EVEN:  c = mk(1'b0, 1'b0, ADDR_IDX,  OP_D_INIT,     C_V_EVEN,       S_NOTP);
			S_SQ:      c = mk(1'b0, 1'b0, ADDR_IDX,  OP_SQ,         C_NONE,         S_LOAD);
			S_SQ_CMP:  c = mk(1'b0, 1'b0, ADDR_IDX,  OP_REM_START,  C_SQ_GT_V,      S_ISP);
			S_DIV:     c = mk(1'b0, 1'b0, ADDR_IDX,  OP_NONE,       C_REM_BUSY,     S_DIV);
			S_DIV_CHK: c = mk(1'b0, 1'b0, ADDR_IDX,  OP_D_ADD2,     C_REM_ZERO,     S_NOTP);
			S_NEXT_D:  c = mk(1'b0, 1'b0, ADDR_IDX,  OP_NONE,       C_ALWAYS,       S_SQ);
			S_NOTP:    c = mk(1'b0, 1'b0, ADDR_IDX,  OP_WR_NP,      C_ALWAYS,       S_FL_CHK);
			S_ISP:     c = mk(1'b0, 1'b0, ADDR_IDX,  OP_WR_P,       C_ALWAYS,       S_FL_CHK);
			S_PT_INIT: c = mk(1'b0, 1'b0, ADDR_IDX,  OP_PT_INIT,    C_NONE,         S_LOAD);
			S_PT_TOP:  c = mk(1'b0, 1'b0, ADDR_IDX,  OP_NONE,       C_SLOT_ZERO,    S_EM_INIT);
			S_PT_DEC:  c = mk(1'b0, 1'b0, ADDR_IDX,  OP_DEC_SLOT,   C_NONE,         S_LOAD);
			S_PT_RD:   c = mk(1'b0, 1'b1, ADDR_SLOT, OP_NONE,       C_NONE,         S_LOAD);
			S_PT_CHK:  c = mk(1'b0, 1'b0, ADDR_IDX,  OP_LD_A,       C_RD_FLAG,      S_PT_TOP);
			S_SC_TOP:  c = mk(1'b0, 1'b1, ADDR_SCAN, OP_NONE,       C_SCAN_GE_SLOT, S_PT_TOP);
			S_SC_CHK:  c = mk(1'b0, 1'b0, ADDR_IDX,  OP_NONE,       C_RD_FLAG,      S_SWAP_A);
			S_SC_INC:  c = mk(1'b0, 1'b0, ADDR_IDX,  OP_INC_SCAN,   C_ALWAYS,       S_SC_TOP);
			S_SWAP_A:  c = mk(1'b0, 1'b0, ADDR_IDX,  OP_WR_SLOT_RD, C_NONE,         S_LOAD);
			S_SWAP_B:  c = mk(1'b0, 1'b0, ADDR_IDX,  OP_WR_SCAN_A,  C_ALWAYS,       S_PT_TOP);
			S_EM_INIT: c = mk(1'b0, 1'b0, ADDR_IDX,  OP_CLR_IDX,    C_NONE,         S_LOAD);
			S_EM_RD:   c = mk(1'b0, 1'b1, ADDR_IDX,  OP_NONE,       C_OUT_HOLD,     S_EM_RD);
			S_EM_LD:   c = mk(1'b0, 1'b0, ADDR_IDX,  OP_OUT_LD,     C_NONE,         S_LOAD);
			S_EM_CHK:  c = mk(1'b0, 1'b0, ADDR_IDX,  OP_NONE,       C_IDX_MORE,     S_EM_RD);
			S_FIN:     c = mk(1'b0, 1'b0, ADDR_IDX,  OP_CLR_CNT,    C_ALWAYS,       S_LOAD);
			default:   c = mk(1'b0, 1'b0, ADDR_IDX,  OP_NONE,       C_ALWAYS,       S_LOAD);
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

>>> sv/ppe_rem.sv
`timescale 1ns / 1ps
`default_nettype none
// Restoring remainder unit, one quotient bit per cycle over all VALUE_BITS dividend bits.
// Depends on ppe_pkg for the status struct.

module ppe_rem #(
	parameter int VALUE_BITS = ppe_pkg::VALUE_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [VALUE_BITS-1:0] dividend,
	input  wire logic [VALUE_BITS-1:0] divisor,
	output ppe_pkg::rem_stat_t         stat
);
	import ppe_pkg::*;

	localparam int NW = $clog2(VALUE_BITS + 1);

	logic                  busy_q;
	logic [NW-1:0]         n_q;
	logic [VALUE_BITS-1:0] dv_q;
	logic [VALUE_BITS-1:0] dsr_q;
	logic [VALUE_BITS-1:0] rem_q;
	logic [VALUE_BITS:0]   trial;
	logic [VALUE_BITS:0]   diff;
	logic                  fits;

	assign trial = {rem_q, dv_q[VALUE_BITS-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign fits  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			n_q    <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			n_q    <= NW'(VALUE_BITS);
		end else if (busy_q) begin
			n_q <= n_q - NW'(1);
			if (n_q == NW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dv_q  <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dv_q  <= dv_q << 1;
			rem_q <= fits ? diff[VALUE_BITS-1:0] : trial[VALUE_BITS-1:0];
		end
	end

	assign stat.busy = busy_q;
	assign stat.zero = (rem_q == '0);

endmodule

`default_nettype wire

>>> sv/prime_partition_to_end_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Prime partition core: loads a list, moves its primes to the tail, streams it back out.
// Microcoded sequencer over one element store; depends on ppe_pkg and ppe_rem.
//
// Use:
//   s_* channel takes one list element per beat, s_tlast closes the list. While the
//   list loads, s_tready is high and one beat is taken every cycle that s_tvalid is
//   high. Elements beyond MAX_ELEMENTS are dropped; a dropped beat with s_tlast still
//   closes the list. After the closing beat s_tready stays low until the last element
//   has been loaded into the output register.
//   Primality pass: each element is read and tested for < 2, < 4 and even, then
//   trial divided by odd divisors from 3 up to the square root in the remainder unit.
//   Partition pass: each slot from the tail has its prime flag read; a non-prime slot
//   scans from the head and the scan ends at the slot or swaps in the first prime found.
//   Emission: per m_* beat a store read, an output register load and a loop check;
//   m_tlast marks the final element. A stalled m_tready holds the output register and
//   pauses the sequencer; after the last beat, the loop check and S_FIN lead back to the load step.
//   Reset: list empty, sequencer at the load step, m_tvalid low. The store holds no
//   reset value; only entries of the current list are ever read.

module prime_partition_to_end_core #(
	parameter int MAX_ELEMENTS = ppe_pkg::MAX_ELEMENTS_DEF,
	parameter int VALUE_BITS   = ppe_pkg::VALUE_BITS_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 s_tvalid,
	output logic                                      s_tready,
	input  wire logic [((VALUE_BITS + 7) / 8) * 8-1:0] s_tdata,  // value
	input  wire logic                                 s_tlast,
	output logic                                      m_tvalid,
	input  wire logic                                 m_tready,
	output logic [((VALUE_BITS + 7) / 8) * 8-1:0]      m_tdata,  // value_res
	output logic                                      m_tlast
);
	import ppe_pkg::*;

	localparam int TDW = ((VALUE_BITS + 7) / 8) * 8;
	localparam int AW  = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
	localparam int CW  = $clog2(MAX_ELEMENTS + 1);
	localparam int SQW = 2 * VALUE_BITS;

	step_t                 pc_q;
	ctrl_t                 cw;
	logic                  take;
	logic                  beat_in;

	logic [CW-1:0]         cnt_q;
	logic [CW-1:0]         idx_q;
	logic [CW-1:0]         slot_q;
	logic [CW-1:0]         scan_q;
	logic [VALUE_BITS-1:0] v_q;
	logic [VALUE_BITS-1:0] d_q;
	logic [SQW-1:0]        sq_q;
	logic [VALUE_BITS:0]   a_q;
	logic [VALUE_BITS:0]   rd_q;
	logic                  out_valid_q;
	logic [VALUE_BITS-1:0] out_val_q;
	logic                  out_last_q;

	// store word: {prime flag, value}
	logic [VALUE_BITS:0]   mem [MAX_ELEMENTS];
	logic [AW-1:0]         rd_addr;
	logic [AW-1:0]         wr_addr;
	logic [VALUE_BITS:0]   wr_data;
	logic                  wr_en;

	rem_stat_t             rem_stat;

	assign cw       = ucode(pc_q);
	assign s_tready = cw.rdy;
	assign beat_in  = s_tvalid & cw.rdy;

	ppe_rem #(
		.VALUE_BITS(VALUE_BITS)
	) u_rem (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cw.op == OP_REM_START),
		.dividend(v_q),
		.divisor (d_q),
		.stat    (rem_stat)
	);

	always_comb begin
		unique case (cw.rd_sel)
			ADDR_IDX:  rd_addr = idx_q[AW-1:0];
			ADDR_SLOT: rd_addr = slot_q[AW-1:0];
			ADDR_SCAN: rd_addr = scan_q[AW-1:0];
			default:   rd_addr = idx_q[AW-1:0];
		endcase
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = idx_q[AW-1:0];
		wr_data = {1'b0, v_q};
		case (cw.op)
			OP_LOAD: begin
				wr_en   = beat_in && (cnt_q < CW'(MAX_ELEMENTS));
				wr_addr = cnt_q[AW-1:0];
				wr_data = {1'b0, s_tdata[VALUE_BITS-1:0]};
			end
			OP_WR_NP: begin
				wr_en   = 1'b1;
				wr_data = {1'b0, v_q};
			end
			OP_WR_P: begin
				wr_en   = 1'b1;
				wr_data = {1'b1, v_q};
			end
			OP_WR_SLOT_RD: begin
				wr_en   = 1'b1;
				wr_addr = slot_q[AW-1:0];
				wr_data = rd_q;
			end
			OP_WR_SCAN_A: begin
				wr_en   = 1'b1;
				wr_addr = scan_q[AW-1:0];
				wr_data = a_q;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (cw.rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_comb begin
		unique case (cw.cond)
			C_NONE:         take = 1'b0;
			C_ALWAYS:       take = 1'b1;
			C_NOT_CLOSE:    take = !(beat_in && s_tlast);
			C_IDX_DONE:     take = (idx_q == cnt_q);
			C_IDX_MORE:     take = (idx_q != cnt_q);
			C_V_LT2:        take = $signed(v_q) < $signed(VALUE_BITS'(2));
			C_V_LT4:        take = v_q < VALUE_BITS'(4);
			C_V_EVEN:       take = !v_q[0];
			C_SQ_GT_V:      take = sq_q > SQW'(v_q);
			C_REM_BUSY:     take = rem_stat.busy;
			C_REM_ZERO:     take = rem_stat.zero;
			C_SLOT_ZERO:    take = (slot_q == '0);
			C_RD_FLAG:      take = rd_q[VALUE_BITS];
			C_SCAN_GE_SLOT: take = (scan_q >= slot_q);
			C_OUT_HOLD:     take = out_valid_q && !m_tready;
			default:        take = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= S_LOAD;
			cnt_q       <= '0;
			idx_q       <= '0;
			slot_q      <= '0;
			scan_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			pc_q <= take ? cw.target : pc_q + step_t'(1);
			if (cw.op == OP_OUT_LD) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (cw.op)
				OP_LOAD: begin
					if (beat_in && (cnt_q < CW'(MAX_ELEMENTS))) begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				OP_CLR_IDX:  idx_q <= '0;
				OP_WR_NP,
				OP_WR_P,
				OP_OUT_LD:   idx_q <= idx_q + CW'(1);
				OP_PT_INIT: begin
					slot_q <= cnt_q;
					scan_q <= '0;
				end
				OP_DEC_SLOT: slot_q <= slot_q - CW'(1);
				OP_INC_SCAN: scan_q <= scan_q + CW'(1);
				OP_CLR_CNT:  cnt_q <= '0;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cw.op)
			OP_LD_V:   v_q <= rd_q[VALUE_BITS-1:0];
			OP_D_INIT: d_q <= VALUE_BITS'(3);
			OP_D_ADD2: d_q <= d_q + VALUE_BITS'(2);
			OP_SQ:     sq_q <= SQW'(d_q) * SQW'(d_q);
			OP_LD_A:   a_q <= rd_q;
			OP_OUT_LD: begin
				out_val_q  <= rd_q[VALUE_BITS-1:0];
				out_last_q <= (CW'(idx_q + CW'(1)) == cnt_q);
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = TDW'(out_val_q);
	assign m_tlast  = out_last_q;

endmodule

`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 1ps
// Testbench for prime_partition_to_end_core: lists of signed values in, reordered lists out.
// Directed table, then random lists checked against a local partition predictor.
// Depends on ppe_pkg and prime_partition_to_end_core.

module testbench;

	localparam int VW        = ppe_pkg::VALUE_BITS_DEF;
	localparam int TW        = ((VW + 7) / 8) * 8;
	localparam int LIST_MAX  = ppe_pkg::MAX_ELEMENTS_DEF;
	localparam int RAND_ITEMS = 390;
	// the limit covers elements near the top of the range, which need the most trial divisions, plus stalls
	localparam int CYCLE_LIMIT = 4000000;
	localparam int TAIL_CYCLES = 40;

	typedef struct packed {
		logic [VW-1:0] value;
		logic          last;
	} out_beat_t;

	typedef struct packed {
		logic [VW-1:0] value;
		logic          last;
		logic          known;
		logic [VW-1:0] exp_value;
	} row_t;

	localparam int NUM_ROWS = 23;
	localparam row_t ROWS [NUM_ROWS] = '{
		'{16'h8000, 1'b1, 1'b1, 16'h8000},
		'{16'h7FFF, 1'b1, 1'b1, 16'h7FFF},
		'{16'd0,    1'b0, 1'b1, 16'd0},
		'{16'd1,    1'b0, 1'b1, 16'd1},
		'{16'd2,    1'b1, 1'b1, 16'd2},
		'{16'd3,    1'b0, 1'b1, 16'd4},
		'{16'd4,    1'b1, 1'b1, 16'd3},
		'{16'hFFFF, 1'b0, 1'b1, 16'hFFFF},
		'{16'hFFF9, 1'b0, 1'b1, 16'hFFF9},
		'{16'd32749, 1'b1, 1'b1, 16'd32749},
		'{16'd9,    1'b0, 1'b0, 16'd0},
		'{16'd5,    1'b0, 1'b0, 16'd0},
		'{16'd8,    1'b0, 1'b0, 16'd0},
		'{16'd7,    1'b1, 1'b0, 16'd0},
		'{16'd25,   1'b0, 1'b0, 16'd0},
		'{16'd49,   1'b0, 1'b0, 16'd0},
		'{16'd121,  1'b1, 1'b0, 16'd0},
		'{16'd2,    1'b1, 1'b1, 16'd2},
		'{16'hFFFE, 1'b0, 1'b0, 16'd0},
		'{16'd17,   1'b0, 1'b0, 16'd0},
		'{16'd10,   1'b0, 1'b0, 16'd0},
		'{16'd13,   1'b1, 1'b0, 16'd0},
		'{16'd1,    1'b1, 1'b1, 16'd1}
	};

	logic          clk;
	logic          arst_n;
	logic          s_tvalid;
	logic          s_tready;
	logic [TW-1:0] s_tdata;   // value
	logic          s_tlast;
	logic          m_tvalid;
	logic          m_tready;
	logic [TW-1:0] m_tdata;   // value_res
	logic          m_tlast;

	logic [VW-1:0] list_vals [$];
	bit            list_known [$];
	logic [VW-1:0] list_typed [$];
	out_beat_t     expected_out [$];

	int src_idle;
	int snk_idle;
	int mismatches = 0;
	int cycles = 0;

	prime_partition_to_end_core DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic bit is_prime16(input logic signed [VW-1:0] v);
		int n;
		int d;
		n = v;
		if (n < 2)
			return 1'b0;
		if (n < 4)
			return 1'b1;
		if (n % 2 == 0)
			return 1'b0;
		for (d = 3; d * d <= n; d += 2)
			if (n % d == 0)
				return 1'b0;
		return 1'b1;
	endfunction

	// walk from the tail; a non-prime slot takes the first prime in front of it
	task automatic partition_list();
		logic [VW-1:0] vals [$];
		logic [VW-1:0] t;
		out_beat_t     b;
		int            slot;
		int            scan;
		bit            swapped;
		vals = list_vals;
		for (slot = vals.size() - 1; slot >= 0; slot--) begin
			if (!is_prime16(vals[slot])) begin
				swapped = 1'b0;
				for (scan = 0; scan < slot && !swapped; scan++) begin
					if (is_prime16(vals[scan])) begin
						t = vals[slot];
						vals[slot] = vals[scan];
						vals[scan] = t;
						swapped = 1'b1;
					end
				end
			end
		end
		for (slot = 0; slot < vals.size(); slot++) begin
			b.value = list_known[slot] ? list_typed[slot] : vals[slot];
			b.last  = (slot == vals.size() - 1);
			expected_out.push_back(b);
		end
		list_vals.delete();
		list_known.delete();
		list_typed.delete();
	endtask

	task automatic send_beat(input logic [VW-1:0] v, input logic l, input bit known,
			input logic [VW-1:0] typed);
		while ($urandom_range(0, 99) < src_idle) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= TW'(v);
		s_tlast  <= l;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (list_vals.size() < LIST_MAX) begin
			list_vals.push_back(v);
			list_known.push_back(known);
			list_typed.push_back(typed);
		end
		if (l)
			partition_list();
		@(negedge clk);
	endtask

	function automatic logic [VW-1:0] rand_value();
		case ($urandom_range(0, 5))
			0:       return VW'($urandom_range(0, 40));
			1:       return VW'($urandom_range(2, 300));
			2:       return VW'(-$urandom_range(1, 32768));
			3:       return VW'($urandom_range(32600, 32767));
			default: return VW'($urandom);
		endcase
	endfunction

	task automatic drain();
		s_tvalid <= 1'b0;
		do
			@(negedge clk);
		while (expected_out.size() != 0);
	endtask

	always @(negedge clk)
		m_tready <= ($urandom_range(0, 99) >= snk_idle);

	always @(posedge clk) begin : monitor
		out_beat_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_out.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected beat: value=%0d last=%0b",
						$signed(m_tdata[VW-1:0]), m_tlast);
			end else begin
				want = expected_out.pop_front();
				if (m_tdata[VW-1:0] !== want.value || m_tlast !== want.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected value=%0d last=%0b, got value=%0d last=%0b",
							$signed(want.value), want.last,
							$signed(m_tdata[VW-1:0]), m_tlast);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		int rand_done;
		int list_no;
		int len;
		int k;
		int phase_no;
		clk        = 1'b0;
		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		s_tlast    = 1'b0;
		src_idle   = 33;
		snk_idle   = 65;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (k = 0; k < NUM_ROWS; k++)
			send_beat(ROWS[k].value, ROWS[k].last, ROWS[k].known, ROWS[k].exp_value);

		// random lists; a full list and an overflowing one early on
		rand_done = 0;
		list_no   = 0;
		phase_no  = 0;
		while (rand_done < RAND_ITEMS) begin
			if (list_no == 1)
				len = LIST_MAX;
			else if (list_no == 3)
				len = LIST_MAX + 3;
			else if ($urandom_range(0, 9) == 0)
				len = 1;
			else
				len = $urandom_range(2, 12);
			for (k = 0; k < len; k++)
				send_beat(rand_value(), k == len - 1, 1'b0, '0);
			rand_done += len;
			list_no++;
			if (phase_no == 0 && rand_done >= RAND_ITEMS / 3) begin
				drain();
				src_idle = 65;
				snk_idle = 33;
				phase_no = 1;
			end else if (phase_no == 1 && rand_done >= 2 * RAND_ITEMS / 3) begin
				src_idle = 0;
				snk_idle = 0;
				phase_no = 2;
			end
		end

		drain();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (mismatches == 0 && expected_out.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
